>>> hw/rtl/ibbs_pkg.sv
// ----------------------------------------------------------------------------
// ibbs_pkg
// shared widths, register codes and word types of the binning block
// ----------------------------------------------------------------------------
package ibbs_pkg;

  localparam int DIM_W        = 13;   // image dimension and position counters
  localparam int PIX_W        = 20;   // input pixel value
  localparam int SUM_W        = 28;   // binned sum
  localparam int FACT_REG_W   = 5;    // binning factor registers
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 13;
  localparam int HEIGHT_LIMIT = 4096;

  localparam logic [DIM_W-1:0]      WIDTH_RESET  = DIM_W'(2048);
  localparam logic [DIM_W-1:0]      HEIGHT_RESET = DIM_W'(2048);
  localparam logic [FACT_REG_W-1:0] FACT_RESET   = FACT_REG_W'(1);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 2'd0,
    REG_IMAGE_HEIGHT = 2'd1,
    REG_X_FACTOR     = 2'd2,
    REG_Y_FACTOR     = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [SUM_W-1:0] binned_sum;
    logic             frame_last;
  } out_word_t;

endpackage

>>> hw/rtl/ibbs_if.sv
// ----------------------------------------------------------------------------
// ibbs interfaces
// valid/ready channels for pixels, binned results and register writes
// ----------------------------------------------------------------------------
interface ibbs_pix_if
  import ibbs_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_value;
  logic             frame_start;

  modport source (output valid, pixel_value, frame_start, input ready);
  modport sink   (input valid, pixel_value, frame_start, output ready);
endinterface

interface ibbs_bin_if
  import ibbs_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [SUM_W-1:0] binned_sum;
  logic             frame_last;

  modport source (output valid, binned_sum, frame_last, input ready);
  modport sink   (input valid, binned_sum, frame_last, output ready);
endinterface

interface ibbs_cfg_if
  import ibbs_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> hw/rtl/ibbs_ram.sv
// ----------------------------------------------------------------------------
// ibbs_ram
// simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module ibbs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

>>> hw/rtl/ibbs_div.sv
// ----------------------------------------------------------------------------
// ibbs_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module ibbs_div #(
  parameter int N = 13,
  parameter int M = 5
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [N-1:0] dividend_i,
  input  logic [M-1:0] divisor_i,
  output logic         busy_o,
  output logic [N-1:0] quot_o,
  output logic [M-1:0] rem_o
);

  localparam int CNT_W = $clog2(N + 1);

  logic [CNT_W-1:0] cnt_q;
  logic             busy_q;
  logic [N-1:0]     quo_q;
  logic [M-1:0]     rem_q;
  logic [M-1:0]     dvs_q;
  logic [M:0]       trial;
  logic             take;

  assign trial = {rem_q, quo_q[N-1]};
  assign take  = trial >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CNT_W'(N);
    end else if (busy_q) begin
      cnt_q <= cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[N-2:0], take};
      rem_q <= take ? M'(trial - {1'b0, dvs_q}) : M'(trial);
    end
  end

  assign busy_o = busy_q;
  assign quot_o = quo_q;
  assign rem_o  = rem_q;

endmodule

>>> hw/rtl/image_block_binning_sum_top.sv
// ----------------------------------------------------------------------------
// image_block_binning_sum_top
// sums blocks of x_factor by y_factor pixels of a raster stream into one word
// ----------------------------------------------------------------------------
// throughput: one pixel per cycle unless the input is held off; the pixel that
//   completes a block is registered into stage 1, then into the output queue
// after reset and after every register write the pixel input is held off
//   while serial dividers work out the output size and bin position
// the column sum ram is not cleared; the user, not the block, must see that an
//   entry is written by the first row of a block before a later row reads it
module image_block_binning_sum_top
  import ibbs_pkg::*;
#(
  parameter int MAX_LINE_WIDTH = 4096,
  parameter int MAX_FACTOR     = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  ibbs_pix_if.sink   pix_i,
  ibbs_bin_if.source bin_o,
  ibbs_cfg_if.sink   cfg_i
);

  localparam int AW   = $clog2(MAX_LINE_WIDTH);
  localparam int CF_W = $clog2(MAX_FACTOR + 1);
  localparam int HP_W = PIX_W + $clog2(MAX_FACTOR);

  // configuration registers
  logic [DIM_W-1:0]      width_q, height_q;
  logic [FACT_REG_W-1:0] xf_q, yf_q;
  logic                  cfg_fire;

  // saturated working values
  logic [DIM_W-1:0] w_c, h_c;
  logic [CF_W-1:0]  xf_c, yf_c;

  // recompute control, runs the dividers after reset and every write
  logic start_q, recomp_q;
  logic busy_cx, busy_ry, busy_oc, busy_or;
  logic div_done;
  logic [DIM_W-1:0] div_bx, div_by, div_oc, div_or;
  logic [CF_W-1:0]  div_rx, div_ry;

  // position state
  logic [DIM_W-1:0] col_q, row_q, bx_q, by_q, ocols_q, orows_q;
  logic [CF_W-1:0]  offx_q, offy_q, rx_q, ry_q;
  logic [HP_W-1:0]  hp_q;

  // stage 0, the pixel being taken
  logic             in_fire;
  logic [DIM_W-1:0] col0, row0, bx0, by0;
  logic [CF_W-1:0]  offx0, offy0, rx0, ry0;
  logic [HP_W-1:0]  hp_new;
  logic             hit0, last0, fwd0;
  logic [AW-1:0]    addr0;
  logic [DIM_W-1:0] col_n, row_n, bx_n, by_n;
  logic [CF_W-1:0]  offx_n, offy_n, rx_n, ry_n;

  // stage 1, ram read back and sum write
  logic             s1_valid_q, s1_res_q, s1_last_q, s1_first_q, s1_fwd_q;
  logic [AW-1:0]    s1_addr_q;
  logic [HP_W-1:0]  s1_hp_q;
  logic [SUM_W-1:0] rdata, wr_last_q, s1_base, s1_sum;

  // output queue of result words
  out_word_t  fifo_q [4];
  logic [1:0] wr_ptr_q, rd_ptr_q;
  logic [2:0] cnt_q;
  logic       push, pop;
  logic [3:0] room_need;

  // --------------------------------------------------------------------------
  // register port, always ready
  // --------------------------------------------------------------------------
  assign cfg_i.ready = 1'b1;
  assign cfg_fire    = cfg_i.valid && cfg_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RESET;
      height_q <= HEIGHT_RESET;
      xf_q     <= FACT_RESET;
      yf_q     <= FACT_RESET;
    end else if (cfg_fire) begin
      unique case (cfg_reg_e'(cfg_i.index))
        REG_IMAGE_WIDTH:  width_q  <= DIM_W'(cfg_i.data);
        REG_IMAGE_HEIGHT: height_q <= DIM_W'(cfg_i.data);
        REG_X_FACTOR:     xf_q     <= FACT_REG_W'(cfg_i.data);
        REG_Y_FACTOR:     yf_q     <= FACT_REG_W'(cfg_i.data);
      endcase
    end
  end

  // saturate the registers to their legal ranges, zero counts as one
  always_comb begin
    if (width_q == '0) begin
      w_c = DIM_W'(1);
    end else if (32'(width_q) > MAX_LINE_WIDTH) begin
      w_c = DIM_W'(MAX_LINE_WIDTH);
    end else begin
      w_c = width_q;
    end
    if (height_q == '0) begin
      h_c = DIM_W'(1);
    end else if (32'(height_q) > HEIGHT_LIMIT) begin
      h_c = DIM_W'(HEIGHT_LIMIT);
    end else begin
      h_c = height_q;
    end
    if (xf_q == '0) begin
      xf_c = CF_W'(1);
    end else if (32'(xf_q) > MAX_FACTOR) begin
      xf_c = CF_W'(MAX_FACTOR);
    end else begin
      xf_c = CF_W'(xf_q);
    end
    if (yf_q == '0) begin
      yf_c = CF_W'(1);
    end else if (32'(yf_q) > MAX_FACTOR) begin
      yf_c = CF_W'(MAX_FACTOR);
    end else begin
      yf_c = CF_W'(yf_q);
    end
  end

  // --------------------------------------------------------------------------
  // dividers: bin column and row of the current position with their
  // remainders, and the output image size
  // --------------------------------------------------------------------------
  ibbs_div #(.N(DIM_W), .M(CF_W)) u_div_col (
    .clk_i, .rst_ni, .start_i(start_q), .dividend_i(col_q), .divisor_i(xf_c),
    .busy_o(busy_cx), .quot_o(div_bx), .rem_o(div_rx)
  );

  ibbs_div #(.N(DIM_W), .M(CF_W)) u_div_row (
    .clk_i, .rst_ni, .start_i(start_q), .dividend_i(row_q), .divisor_i(yf_c),
    .busy_o(busy_ry), .quot_o(div_by), .rem_o(div_ry)
  );

  ibbs_div #(.N(DIM_W), .M(CF_W)) u_div_ocols (
    .clk_i, .rst_ni, .start_i(start_q), .dividend_i(w_c), .divisor_i(xf_c),
    .busy_o(busy_oc), .quot_o(div_oc), .rem_o()
  );

  ibbs_div #(.N(DIM_W), .M(CF_W)) u_div_orows (
    .clk_i, .rst_ni, .start_i(start_q), .dividend_i(h_c), .divisor_i(yf_c),
    .busy_o(busy_or), .quot_o(div_or), .rem_o()
  );

  assign div_done = recomp_q && !start_q &&
                    !(busy_cx || busy_ry || busy_oc || busy_or);

  // a write during a recompute simply starts it again
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q  <= 1'b1;
      recomp_q <= 1'b1;
    end else begin
      start_q <= cfg_fire;
      if (cfg_fire) begin
        recomp_q <= 1'b1;
      end else if (div_done) begin
        recomp_q <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // stage 0: position bookkeeping and ram read of the column sum
  // --------------------------------------------------------------------------
  assign room_need   = {1'b0, cnt_q} + 4'(s1_valid_q && s1_res_q);
  assign pix_i.ready = !recomp_q && (room_need < 4'd4);
  assign in_fire     = pix_i.valid && pix_i.ready;

  always_comb begin
    // frame start forces position (0,0)
    col0  = pix_i.frame_start ? '0 : col_q;
    row0  = pix_i.frame_start ? '0 : row_q;
    offx0 = pix_i.frame_start ? '0 : offx_q;
    offy0 = pix_i.frame_start ? '0 : offy_q;
    bx0   = pix_i.frame_start ? '0 : bx_q;
    by0   = pix_i.frame_start ? '0 : by_q;
    rx0   = pix_i.frame_start ? '0 : rx_q;
    ry0   = pix_i.frame_start ? '0 : ry_q;

    // running sum along the block row
    if (offx0 == '0) begin
      hp_new = HP_W'(pix_i.pixel_value);
    end else begin
      hp_new = hp_q + HP_W'(pix_i.pixel_value);
    end

    // last column of a full block inside the output image
    hit0  = ({1'b0, offx0} + (CF_W+1)'(1) >= {1'b0, xf_c}) &&
            (bx0 < ocols_q) && (by0 < orows_q);
    last0 = ({1'b0, bx0} + (DIM_W+1)'(1) == {1'b0, ocols_q}) &&
            ({1'b0, by0} + (DIM_W+1)'(1) == {1'b0, orows_q});
    addr0 = AW'(bx0);
    fwd0  = s1_valid_q && (s1_addr_q == addr0);

    // advance the position
    col_n  = col0;
    row_n  = row0;
    offx_n = offx0;
    offy_n = offy0;
    bx_n   = bx0;
    by_n   = by0;
    rx_n   = rx0;
    ry_n   = ry0;
    if ({1'b0, col0} + (DIM_W+1)'(1) >= {1'b0, w_c}) begin
      // end of row
      col_n  = '0;
      offx_n = '0;
      bx_n   = '0;
      rx_n   = '0;
      if ({1'b0, row0} + (DIM_W+1)'(1) >= {1'b0, h_c}) begin
        // end of frame
        row_n  = '0;
        offy_n = '0;
        by_n   = '0;
        ry_n   = '0;
      end else begin
        row_n = row0 + DIM_W'(1);
        if ({1'b0, offy0} + (CF_W+1)'(1) >= {1'b0, yf_c}) begin
          offy_n = '0;
        end else begin
          offy_n = offy0 + CF_W'(1);
        end
        if ({1'b0, ry0} + (CF_W+1)'(1) >= {1'b0, yf_c}) begin
          ry_n = '0;
          by_n = by0 + DIM_W'(1);
        end else begin
          ry_n = ry0 + CF_W'(1);
        end
      end
    end else begin
      col_n = col0 + DIM_W'(1);
      if ({1'b0, offx0} + (CF_W+1)'(1) >= {1'b0, xf_c}) begin
        offx_n = '0;
      end else begin
        offx_n = offx0 + CF_W'(1);
      end
      if ({1'b0, rx0} + (CF_W+1)'(1) >= {1'b0, xf_c}) begin
        rx_n = '0;
        bx_n = bx0 + DIM_W'(1);
      end else begin
        rx_n = rx0 + CF_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      row_q   <= '0;
      offx_q  <= '0;
      offy_q  <= '0;
      bx_q    <= '0;
      by_q    <= '0;
      rx_q    <= '0;
      ry_q    <= '0;
      hp_q    <= '0;
      ocols_q <= '0;
      orows_q <= '0;
    end else if (in_fire) begin
      col_q  <= col_n;
      row_q  <= row_n;
      offx_q <= offx_n;
      offy_q <= offy_n;
      bx_q   <= bx_n;
      by_q   <= by_n;
      rx_q   <= rx_n;
      ry_q   <= ry_n;
      hp_q   <= hp_new;
    end else if (div_done) begin
      // bin position under the new factors, output image size
      bx_q    <= div_bx;
      by_q    <= div_by;
      rx_q    <= div_rx;
      ry_q    <= div_ry;
      ocols_q <= div_oc;
      orows_q <= div_or;
    end
  end

  // --------------------------------------------------------------------------
  // column sum ram, one entry per output column
  // --------------------------------------------------------------------------
  ibbs_ram #(.WIDTH(SUM_W), .DEPTH(MAX_LINE_WIDTH)) u_colsum (
    .clk_i,
    .we_i   (s1_valid_q),
    .waddr_i(s1_addr_q),
    .wdata_i(s1_sum),
    .re_i   (in_fire),
    .raddr_i(addr0),
    .rdata_o(rdata)
  );

  // --------------------------------------------------------------------------
  // stage 1: add the block row to the column sum and write it back
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_res_q   <= 1'b0;
    end else begin
      s1_valid_q <= in_fire && hit0;
      s1_res_q   <= in_fire && hit0 &&
                    ({1'b0, offy0} + (CF_W+1)'(1) >= {1'b0, yf_c});
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_last_q  <= last0;
      s1_first_q <= (offy0 == '0);
      s1_fwd_q   <= fwd0;
      s1_addr_q  <= addr0;
      s1_hp_q    <= hp_new;
    end
    if (s1_valid_q) begin
      wr_last_q <= s1_sum;
    end
  end

  // the ram read misses a write to the same entry in the same cycle,
  // so that sum comes from the write-back register instead
  always_comb begin
    if (s1_first_q) begin
      s1_base = '0;
    end else if (s1_fwd_q) begin
      s1_base = wr_last_q;
    end else begin
      s1_base = rdata;
    end
    s1_sum = s1_base + SUM_W'(s1_hp_q);
  end

  // --------------------------------------------------------------------------
  // output queue, deep enough that stage 1 never waits
  // --------------------------------------------------------------------------
  assign push = s1_valid_q && s1_res_q;
  assign pop  = bin_o.valid && bin_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + 2'd1;
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + 2'd1;
      end
      case ({push, pop})
        2'b10:   cnt_q <= cnt_q + 3'd1;
        2'b01:   cnt_q <= cnt_q - 3'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= '{binned_sum: s1_sum, frame_last: s1_last_q};
    end
  end

  assign bin_o.valid      = (cnt_q != '0);
  assign bin_o.binned_sum = fifo_q[rd_ptr_q].binned_sum;
  assign bin_o.frame_last = fifo_q[rd_ptr_q].frame_last;

endmodule

>>> hw/rtl/ibbs_checker.sv
// ----------------------------------------------------------------------------
// ibbs_checker
// port level checks of the binning block, bound to the top level
// ----------------------------------------------------------------------------
module ibbs_checker
  import ibbs_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_ready_i,
  input logic             out_valid_i,
  input logic             out_ready_i,
  input logic [SUM_W-1:0] out_sum_i,
  input logic             out_last_i,
  input logic             cfg_valid_i,
  input logic             cfg_ready_i
);

  // a stalled result word holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      out_valid_i && $stable(out_sum_i) && $stable(out_last_i))
    else $error("result word changed while stalled");

  // register write holds off pixels while the bin position is recomputed
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i && cfg_ready_i |=> !in_ready_i)
    else $error("pixel input ready right after a register write");

  // a result word only follows a taken pixel that passed stage 1 and the output queue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(in_valid_i && in_ready_i, 2))
    else $error("result word without a completing pixel");

  // nothing is offered on the output straight after reset
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !out_valid_i)
    else $error("result word offered out of reset");

endmodule

bind image_block_binning_sum_top ibbs_checker u_ibbs_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (pix_i.valid),
  .in_ready_i (pix_i.ready),
  .out_valid_i(bin_o.valid),
  .out_ready_i(bin_o.ready),
  .out_sum_i  (bin_o.binned_sum),
  .out_last_i (bin_o.frame_last),
  .cfg_valid_i(cfg_i.valid),
  .cfg_ready_i(cfg_i.ready)
);

>>> tb/sv/image_block_binning_sum_top_tb.sv
// ----------------------------------------------------------------------------
// image_block_binning_sum_top_tb
// drives raster frames through the binning block under several register
// settings and compares every binned word with a block sum worked out here
// ----------------------------------------------------------------------------
module image_block_binning_sum_top_tb;
  import ibbs_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int                IDLE_PCT       = 13;    // chance of a gap per cycle
  localparam int                HOLD_CYCLES    = 300;   // one long sink hold-off
  localparam int                SETTLE_CYCLES  = 8;     // lets pixels that gave no word drain
  localparam int                WATCHDOG_LIMIT = 5000;  // cycles with no word moving
  localparam int                RANDOM_PIXELS  = 1700;
  localparam logic [PIX_W-1:0]  PIX_MAX        = {PIX_W{1'b1}};

  // --------------------------------------------------------------------------
  // block sum tracker: own copy of registers, raster position and column sums
  // --------------------------------------------------------------------------
  class block_sum_tracker;
    localparam int LINE_MAX = 4096;
    localparam int FACT_MAX = 16;

    logic [DIM_W-1:0]      width_reg;
    logic [DIM_W-1:0]      height_reg;
    logic [FACT_REG_W-1:0] x_fact_reg;
    logic [FACT_REG_W-1:0] y_fact_reg;
    logic [DIM_W-1:0]      col_pos;
    logic [DIM_W-1:0]      row_pos;
    logic [FACT_REG_W-1:0] x_off;
    logic [FACT_REG_W-1:0] y_off;
    logic [SUM_W-1:0]      row_acc;
    logic [SUM_W-1:0]      col_sums [LINE_MAX];
    bit                    col_written [LINE_MAX];
    out_word_t             pending_sums [$];
    int unsigned           pixels_in;
    int unsigned           words_out;
    int unsigned           frames_done;
    int unsigned           mismatches;

    function new();
      width_reg  = WIDTH_RESET;
      height_reg = HEIGHT_RESET;
      x_fact_reg = FACT_RESET;
      y_fact_reg = FACT_RESET;
      col_pos    = '0;
      row_pos    = '0;
      x_off      = '0;
      y_off      = '0;
      row_acc    = '0;
      foreach (col_written[i]) col_written[i] = 1'b0;
    endfunction

    static function int unsigned sat(int unsigned v, int unsigned hi);
      if (v < 1) return 1;
      if (v > hi) return hi;
      return v;
    endfunction

    function void set_reg(cfg_reg_e idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_IMAGE_WIDTH:  width_reg  = data[DIM_W-1:0];
        REG_IMAGE_HEIGHT: height_reg = data[DIM_W-1:0];
        REG_X_FACTOR:     x_fact_reg = data[FACT_REG_W-1:0];
        REG_Y_FACTOR:     y_fact_reg = data[FACT_REG_W-1:0];
        default: ;
      endcase
    endfunction

    // would the next pixel, taken without a frame start, read a column sum
    // that nothing has written since reset
    function bit hits_blank_column();
      int unsigned xf, yf, bx, by;
      xf = sat(x_fact_reg, FACT_MAX);
      yf = sat(y_fact_reg, FACT_MAX);
      bx = col_pos / xf;
      by = row_pos / yf;
      return x_off + 1 >= xf && bx < sat(width_reg, LINE_MAX) / xf &&
             by < sat(height_reg, HEIGHT_LIMIT) / yf && y_off != 0 && !col_written[bx];
    endfunction

    function void take_pixel(logic [PIX_W-1:0] value, logic start);
      int unsigned      w, h, xf, yf, bx, by;
      logic [SUM_W-1:0] total;
      out_word_t        word;
      w  = sat(width_reg, LINE_MAX);
      h  = sat(height_reg, HEIGHT_LIMIT);
      xf = sat(x_fact_reg, FACT_MAX);
      yf = sat(y_fact_reg, FACT_MAX);
      pixels_in++;
      if (start) begin
        col_pos = '0;
        row_pos = '0;
        x_off   = '0;
        y_off   = '0;
      end
      if (x_off == 0) row_acc = SUM_W'(value);
      else row_acc = row_acc + SUM_W'(value);
      bx = col_pos / xf;
      by = row_pos / yf;
      if (x_off + 1 >= xf && bx < w / xf && by < h / yf) begin
        total = (y_off == 0) ? row_acc : col_sums[bx] + row_acc;
        col_sums[bx]    = total;
        col_written[bx] = 1'b1;
        if (y_off + 1 >= yf) begin
          word.binned_sum = total;
          word.frame_last = (bx + 1 == w / xf) && (by + 1 == h / yf);
          pending_sums.push_back(word);
        end
      end
      // raster advance, wrapping at row and frame end
      if (col_pos + 1 >= w) begin
        col_pos = '0;
        x_off   = '0;
        if (row_pos + 1 >= h) begin
          row_pos = '0;
          y_off   = '0;
        end else begin
          row_pos++;
          y_off = (y_off + 1 >= yf) ? '0 : y_off + 1'b1;
        end
      end else begin
        col_pos++;
        x_off = (x_off + 1 >= xf) ? '0 : x_off + 1'b1;
      end
    endfunction

    task report(string msg);
      mismatches++;
      if (mismatches <= 40) $display("mismatch %0d: %s", mismatches, msg);
    endtask

    task check_word(out_word_t got);
      out_word_t want;
      if (pending_sums.size() == 0) begin
        report($sformatf("word with nothing pending: sum %0d last %0b",
                         got.binned_sum, got.frame_last));
        return;
      end
      want = pending_sums.pop_front();
      words_out++;
      if (want.frame_last) frames_done++;
      if (got.binned_sum !== want.binned_sum)
        report($sformatf("word %0d: sum %0d, wanted %0d",
                         words_out, got.binned_sum, want.binned_sum));
      if (got.frame_last !== want.frame_last)
        report($sformatf("word %0d: frame_last %0b, wanted %0b",
                         words_out, got.frame_last, want.frame_last));
    endtask
  endclass

  // --------------------------------------------------------------------------
  // clock, reset, channels and the block
  // --------------------------------------------------------------------------
  logic        clk_i  = 1'b0;
  logic        rst_ni = 1'b0;
  bit          steady   = 1'b0;   // no gaps on either side while set
  bit          hold_req = 1'b0;   // asks the sink for its long hold-off
  int unsigned reg_writes = 0;
  int unsigned quiet_cycles = 0;

  block_sum_tracker sums = new();

  ibbs_pix_if pix ();
  ibbs_bin_if bin ();
  ibbs_cfg_if cfg ();

  image_block_binning_sum_top uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .pix_i  (pix),
    .bin_o  (bin),
    .cfg_i  (cfg)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // helpers for the pixel side and the register port
  // --------------------------------------------------------------------------

  // factor register word: low bits carry the factor, the rest is random
  function automatic logic [CFG_DATA_W-1:0] fact_word(int unsigned f);
    logic [CFG_DATA_W-1:0] v;
    v = CFG_DATA_W'($urandom());
    v[FACT_REG_W-1:0] = f[FACT_REG_W-1:0];
    return v;
  endfunction

  // heavy mode leans towards full-scale pixels to push the sums to the top
  function automatic logic [PIX_W-1:0] rand_pixel(bit heavy);
    int unsigned r;
    r = $urandom_range(15);
    if (heavy) return (r < 12) ? PIX_MAX : PIX_W'($urandom());
    if (r == 0) return '0;
    if (r == 1) return PIX_MAX;
    return PIX_W'($urandom());
  endfunction

  // offers one pixel word and waits for it to be taken; valid stays high
  // afterwards so back-to-back words need no second assignment in one step
  task automatic drive_pixel(logic [PIX_W-1:0] value, logic start);
    logic fs;
    fs = start;
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      pix.valid <= 1'b0;
      @(posedge clk_i);
    end
    // a row of a block must never read a column sum that was never written
    if (!fs && sums.hits_blank_column()) fs = 1'b1;
    pix.valid       <= 1'b1;
    pix.pixel_value <= value;
    pix.frame_start <= fs;
    do @(posedge clk_i); while (pix.ready !== 1'b1);
    sums.take_pixel(value, fs);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [CFG_DATA_W-1:0] data);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= data;
    do @(posedge clk_i); while (cfg.ready !== 1'b1);
    sums.set_reg(idx, data);
    reg_writes++;
  endtask

  // waits until every pending word has come out, then lets any pixel that
  // gave no word drain through the pipeline
  task automatic settle();
    pix.valid <= 1'b0;
    while (sums.pending_sums.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // mask bit 0 width, 1 height, 2 x factor, 3 y factor
  task automatic configure(logic [3:0] which, logic [CFG_DATA_W-1:0] w,
                           logic [CFG_DATA_W-1:0] h, logic [CFG_DATA_W-1:0] xf,
                           logic [CFG_DATA_W-1:0] yf);
    settle();
    if (which[0]) write_reg(REG_IMAGE_WIDTH, w);
    if (which[1]) write_reg(REG_IMAGE_HEIGHT, h);
    if (which[2]) write_reg(REG_X_FACTOR, xf);
    if (which[3]) write_reg(REG_Y_FACTOR, yf);
    cfg.valid <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // sink side: random ready with one long hold-off, checks every word taken
  // --------------------------------------------------------------------------
  initial begin : sink_side
    int unsigned hold_left;
    bit          hold_done;
    out_word_t   got;
    hold_left = 0;
    hold_done = 1'b0;
    bin.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (bin.valid === 1'b1 && bin.ready === 1'b1) begin
        got.binned_sum = bin.binned_sum;
        got.frame_last = bin.frame_last;
        sums.check_word(got);
      end
      // the hold-off is counted here so the source keeps offering pixels
      // and the block has to fill up and stall its input
      if (hold_req && !hold_done) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left != 0) begin
        hold_left--;
        bin.ready <= 1'b0;
      end else begin
        bin.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // --------------------------------------------------------------------------
  // watchdog: any word moving on any channel restarts the count
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (!rst_ni || (pix.valid && pix.ready) || (bin.valid && bin.ready) ||
        (cfg.valid && cfg.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("watchdog: nothing moved for %0d cycles, %0d words still pending",
               WATCHDOG_LIMIT, sums.pending_sums.size());
      $display("image_block_binning_sum_top_tb: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int unsigned i, f, r, n, len, nframes, frame_px, phase, target;
    int unsigned nw, nh, nx, ny, cur_w, cur_h, cur_x, cur_y;
    logic [3:0]  which;
    bit          heavy, mid_frame;
    logic        start;

    pix.valid       <= 1'b0;
    pix.pixel_value <= '0;
    pix.frame_start <= 1'b0;
    cfg.valid       <= 1'b0;
    cfg.index       <= REG_IMAGE_WIDTH;
    cfg.data        <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset registers: unit factors, so every pixel is a binned word
    drive_pixel('0, 1'b1);
    drive_pixel(PIX_MAX, 1'b0);
    drive_pixel(20'h55555, 1'b0);
    drive_pixel(20'hAAAAA, 1'b0);

    // 3x3 frame in 2x2 blocks: leftover column and row are dropped, then a
    // second frame follows by wrap-around with no frame start
    configure(4'hF, 13'd3, 13'd3, fact_word(2), fact_word(2));
    for (i = 0; i < 12; i++) drive_pixel((i % 2 == 0) ? PIX_MAX : rand_pixel(1'b0), i == 0);

    // x factor changed in the middle of a frame, while the block is idle
    configure(4'b0100, '0, '0, fact_word(1), '0);
    repeat (3) drive_pixel(rand_pixel(1'b0), 1'b0);

    // out-of-range registers: zero width and x factor, oversized height
    configure(4'hF, 13'h0000, 13'h1FFF, 13'h1FE0, fact_word(2));
    for (i = 0; i < 4; i++) drive_pixel(rand_pixel(1'b0), i == 0);

    cur_w = 0;
    cur_h = 13'h1FFF;
    cur_x = 0;
    cur_y = 2;
    mid_frame = 1'b1;
    phase = 0;
    target = sums.pixels_in + RANDOM_PIXELS;

    // random part: mostly whole frames under fresh settings, some cut short,
    // some continued across a register change, a few with absurd registers
    while (sums.pixels_in < target) begin
      heavy = 1'b0;
      which = 4'hF;
      r = $urandom_range(99);
      if (phase == 0) begin
        // dense words while the sink holds off
        nw = 24; nh = 12; nx = 1; ny = 1;
        hold_req = 1'b1;
      end else if (phase == 2 || r < 4) begin
        // biggest blocks, near full-scale pixels
        nx = 16; ny = 16;
        nw = $urandom_range(16, 33);
        nh = $urandom_range(16, 17);
        heavy = 1'b1;
      end else if (r < 14) begin
        nw = $urandom_range(1) ? 0 : $urandom_range(4097, 8191);
        nh = $urandom_range(1) ? 0 : $urandom_range(4097, 8191);
        nx = $urandom_range(1) ? 0 : $urandom_range(17, 31);
        ny = $urandom_range(1) ? 0 : $urandom_range(17, 31);
        which = 4'($urandom_range(1, 15));
      end else begin
        nx = ($urandom_range(4) != 0) ? $urandom_range(1, 4) : $urandom_range(5, 16);
        ny = ($urandom_range(4) != 0) ? $urandom_range(1, 4) : $urandom_range(5, 16);
        nw = nx * $urandom_range(1, (24 / nx > 1) ? 24 / nx : 1);
        nh = ny * $urandom_range(1, (12 / ny > 1) ? 12 / ny : 1);
        if ($urandom_range(2) == 0) nw = nw + $urandom_range(0, nx - 1);
        if ($urandom_range(2) == 0) nh = nh + $urandom_range(0, ny - 1);
        if ($urandom_range(9) == 0) nw = $urandom_range(1, nx);
        if (phase > 2 && $urandom_range(3) == 0) which = 4'($urandom_range(1, 15));
      end
      steady = (phase == 1);
      configure(which, CFG_DATA_W'(nw), CFG_DATA_W'(nh), fact_word(nx), fact_word(ny));
      if (which[0]) cur_w = nw;
      if (which[1]) cur_h = nh;
      if (which[2]) cur_x = nx;
      if (which[3]) cur_y = ny;

      frame_px = block_sum_tracker::sat(cur_w, 4096) * block_sum_tracker::sat(cur_h, 4096);
      if (frame_px > 1200) begin
        n = $urandom_range(40, 100);
        nframes = 1;
      end else begin
        n = frame_px;
        nframes = heavy ? 1 : $urandom_range(1, 2);
      end

      for (f = 0; f < nframes; f++) begin
        len = n;
        if (f == nframes - 1 && n > 1 && $urandom_range(5) == 0) len = $urandom_range(1, n - 1);
        for (i = 0; i < len; i++) begin
          if (i == 0) start = (f == 0 && mid_frame) ? 1'($urandom_range(1))
                                                    : ($urandom_range(3) != 0);
          else start = ($urandom_range(199) == 0);
          drive_pixel(rand_pixel(heavy), start);
        end
        mid_frame = (len != n) || (frame_px > 1200);
      end
      steady = 1'b0;
      phase++;
    end

    settle();
    $display("run covered %0d pixels over %0d settings and %0d register writes",
             sums.pixels_in, phase + 4, reg_writes);
    $display("  %0d binned words checked, %0d of them closing a frame, %0d mismatches",
             sums.words_out, sums.frames_done, sums.mismatches);
    if (sums.mismatches == 0) begin
      $display("image_block_binning_sum_top_tb: clean");
    end else begin
      $display("image_block_binning_sum_top_tb: errors");
    end
    $finish;
  end

endmodule
